@@ src/sspq_pkg.sv @@
// shared constants, types and codes for the stable sorted priority queue
package sspq_pkg;

	// queue geometry and field widths
	localparam int QUEUE_DEPTH    = 1024;
	localparam int ID_WIDTH       = 16;
	localparam int PRIORITY_WIDTH = 4;
	localparam int OCC_WIDTH      = 11;
	localparam int ADDR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

	// command codes
	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_PLACE
	} state_t;

	// one stored entry
	typedef struct packed {
		logic [PRIORITY_WIDTH-1:0] prio;
		logic [ID_WIDTH-1:0]       id;
	} entry_t;

	// access request to the entry store, indexes are logical (head is zero)
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_idx;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_idx;
		entry_t            wr_entry;
	} store_req_t;

endpackage

@@ src/sspq_store.sv @@
// circular entry store: logical to physical mapping and the slot memory
module sspq_store (
	input  logic                 clk,
	input  logic [sspq_pkg::ADDR_W-1:0] base,
	input  sspq_pkg::store_req_t req,
	output sspq_pkg::entry_t     rd_entry
);
	import sspq_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rd_entry_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	// map a logical slot onto the ring starting at base
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] b,
		input logic [ADDR_W-1:0] idx);
		logic [ADDR_W:0] sum;
		sum = {1'b0, b} + {1'b0, idx};
		if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (ADDR_W+1)'(QUEUE_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	assign rd_addr = phys(base, req.rd_idx);
	assign wr_addr = phys(base, req.wr_idx);

	// slot memory write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wr_addr] <= req.wr_entry;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

@@ src/stable_sorted_priority_queue.sv @@
// Stable sorted priority queue: sorted insert and head pop over a ring memory.
//
// Usage: drive cmd, req_id and req_priority with start; the command is taken at
// a clock edge where start is high and busy is low. cmd 0 inserts (id, priority)
// behind every held entry of lower or equal priority; cmd 1 removes the head.
// Each command gives one result transaction: done is high for exactly one cycle
// with status, head_id, head_priority and occupancy (entries held afterwards).
// Results cannot be stalled; the receiver must take them when done is high.
// Steps from the accept edge to done:
//   insert into an empty queue, insert when full, pop when empty: no memory read
//   pop: one memory read of the head
//   insert: a scan from the tail shifts each held entry of higher priority, then
//     writes the new entry; the scan moves one entry per cycle from the tail
// busy is low again in the cycle done is high, so a new command can be taken
// there. The head sits at a ring base pointer, so a pop moves no entries.
// Reset clears the entry count and base pointer; the slot memory is not cleared
// and needs no sweep, since only slots below the count are ever read.
module stable_sorted_priority_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cmd,
	input  logic [sspq_pkg::ID_WIDTH-1:0]       req_id,
	input  logic [sspq_pkg::PRIORITY_WIDTH-1:0] req_priority,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [sspq_pkg::ID_WIDTH-1:0]       head_id,
	output logic [sspq_pkg::PRIORITY_WIDTH-1:0] head_priority,
	output logic [sspq_pkg::OCC_WIDTH-1:0]      occupancy
);
	import sspq_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [ADDR_W-1:0] scan_idx_q, scan_idx_d;
	entry_t            new_q;
	entry_t            req_entry;
	entry_t            rd_entry;
	store_req_t        store_req;
	logic              accept;
	logic              is_pop;
	logic              higher;

	logic                      fin;
	status_t                   status_d;
	logic [ID_WIDTH-1:0]       hid_d;
	logic [PRIORITY_WIDTH-1:0] hprio_d;

	logic                      done_q;
	status_t                   status_q;
	logic [ID_WIDTH-1:0]       head_id_q;
	logic [PRIORITY_WIDTH-1:0] head_prio_q;
	logic [OCC_WIDTH-1:0]      occ_q;

	assign accept    = start && (state_q == S_IDLE);
	assign is_pop    = (cmd == CMD_POP);
	assign req_entry = '{prio: req_priority, id: req_id};
	assign higher    = (rd_entry.prio > new_q.prio);

	sspq_store u_store (
		.clk      (clk),
		.base     (base_q),
		.req      (store_req),
		.rd_entry (rd_entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_pop) begin
						if (count_q != '0) state_d = S_POP;
					end else if (count_q != CNT_W'(QUEUE_DEPTH) && count_q != '0) begin
						state_d = S_SCAN;
					end
				end
			end
			S_POP:   state_d = S_IDLE;
			S_SCAN: begin
				if (!higher) begin
					state_d = S_IDLE;
				end else if (scan_idx_q == '0) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory requests, counters and result
	always_comb begin
		store_req  = '0;
		fin        = 1'b0;
		status_d   = ST_OK;
		hid_d      = '0;
		hprio_d    = '0;
		count_d    = count_q;
		base_d     = base_q;
		scan_idx_d = scan_idx_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_pop) begin
						if (count_q == '0) begin
							fin      = 1'b1;
							status_d = ST_EMPTY;
						end else begin
							store_req.rd_en  = 1'b1;
							store_req.rd_idx = '0;
						end
					end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
						fin      = 1'b1;
						status_d = ST_FULL;
					end else if (count_q == '0) begin
						store_req.wr_en    = 1'b1;
						store_req.wr_idx   = '0;
						store_req.wr_entry = req_entry;
						fin                = 1'b1;
						count_d            = count_q + 1'b1;
					end else begin
						store_req.rd_en  = 1'b1;
						store_req.rd_idx = ADDR_W'(count_q - 1'b1);
						scan_idx_d       = ADDR_W'(count_q - 1'b1);
					end
				end
			end
			S_POP: begin
				fin     = 1'b1;
				hid_d   = rd_entry.id;
				hprio_d = rd_entry.prio;
				count_d = count_q - 1'b1;
				base_d  = (base_q == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : base_q + 1'b1;
			end
			S_SCAN: begin
				// shift a higher entry one slot toward the tail, else drop the new one in
				store_req.wr_en  = 1'b1;
				store_req.wr_idx = scan_idx_q + 1'b1;
				if (higher) begin
					store_req.wr_entry = rd_entry;
					if (scan_idx_q != '0) begin
						store_req.rd_en  = 1'b1;
						store_req.rd_idx = scan_idx_q - 1'b1;
						scan_idx_d       = scan_idx_q - 1'b1;
					end
				end else begin
					store_req.wr_entry = new_q;
					fin                = 1'b1;
					count_d            = count_q + 1'b1;
				end
			end
			S_PLACE: begin
				store_req.wr_en    = 1'b1;
				store_req.wr_idx   = '0;
				store_req.wr_entry = new_q;
				fin                = 1'b1;
				count_d            = count_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			base_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			base_q  <= base_d;
			done_q  <= fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_idx_q <= scan_idx_d;
		if (accept) begin
			new_q <= req_entry;
		end
		if (fin) begin
			status_q    <= status_d;
			head_id_q   <= hid_d;
			head_prio_q <= hprio_d;
			occ_q       <= OCC_WIDTH'(count_d);
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign head_id       = head_id_q;
	assign head_priority = head_prio_q;
	assign occupancy     = occ_q;

`ifndef SYNTHESIS
	// a result only appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while sequencer active");

	// entry count never exceeds the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");

	// scan only runs over held entries of a queue with room left
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (CNT_W'(scan_idx_q) < count_q)
			&& (count_q != CNT_W'(QUEUE_DEPTH)))
		else $error("scan index outside held entries");

	// a pop result follows in the cycle after the pop state, with the count one lower
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |=> done_q && status_q == ST_OK
			&& count_q == $past(count_q) - 1'b1)
		else $error("pop did not complete");

	// rejected commands carry no entry
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == ST_FULL || status_q == ST_EMPTY)
			|-> head_id_q == '0 && head_prio_q == '0)
		else $error("rejected command returned an entry");
`endif

endmodule
